### sv/cht_pkg.sv
`timescale 1ns / 1ps

package cht_pkg;

  localparam int KEY_W    = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 3;

  // stream widths, tdata padded to whole bytes
  localparam int S_TDATA_W = ((KEY_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((POS_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_EXEC
  } cht_state_t;

  typedef struct packed {
    logic clr_en;  // clearing pass writes one row
    logic ld_in;   // capture the accepted word
    logic rd_en;   // reduce bucket index and read the row
    logic exec;    // compare, write back, load the result
  } cht_ctl_t;

  typedef struct packed {
    logic clr_last;
  } cht_sts_t;

endpackage

### sv/chained_hash_table_engine.sv
`timescale 1ns / 1ps

// Hash table with BUCKETS buckets, each an ordered chain of up to WAYS 32-bit
// keys; the bucket is the key modulo BUCKETS. Insert appends (duplicates
// allowed, a full bucket drops the key with status 2), search gives the
// position of the first equal key, remove deletes it and closes the gap.
// Each command answers with one word: status (0 ok, 1 not found, 2 full)
// and position, zero unless status is 0. An item goes through capturing the
// key and looking up its byte residues, then reducing them to the bucket
// index and reading the bucket row from the row memory, then comparing all
// ways in parallel and writing the row back, which waits while the output
// register holds an unread result. After reset a clearing pass over all
// BUCKETS rows zeroes the fill counts before the first word is accepted. A
// finished result waits in an output register while the next word is taken in.
module chained_hash_table_engine import cht_pkg::*; #(
  parameter int BUCKETS = 8,
  parameter int WAYS    = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] key
  input  logic [CMD_W-1:0]     s_tuser,   // [1:0] cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [2:0] position, rest zero
  output logic [STATUS_W-1:0]  m_tuser    // [1:0] status
);

  cht_ctl_t         ctl;
  cht_sts_t         sts;
  logic [POS_W-1:0] position;

  cht_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  cht_datapath #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .in_cmd       (s_tuser),
    .in_key       (s_tdata[KEY_W-1:0]),
    .out_status   (m_tuser),
    .out_position (position)
  );

  assign m_tdata = M_TDATA_W'(position);

endmodule

### sv/cht_controller.sv
`timescale 1ns / 1ps

module cht_controller import cht_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  cht_sts_t sts,
  output cht_ctl_t ctl
);

  cht_state_t state, state_next;
  logic       out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    s_tready   = 1'b0;
    case (state)
      S_CLEAR: begin
        ctl.clr_en = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready   = 1'b1;
        ctl.ld_in  = s_tvalid;
        if (s_tvalid) state_next = S_HASH;
      end
      S_HASH: begin
        ctl.rd_en  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // wait for the output register to be free
        if (!out_valid || m_tready) begin
          ctl.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
    out_valid_next = ctl.exec | (out_valid & ~m_tready);
  end

  assign m_tvalid = out_valid;

endmodule

### sv/cht_datapath.sv
`timescale 1ns / 1ps

module cht_datapath import cht_pkg::*; #(
  parameter int BUCKETS = 8,
  parameter int WAYS    = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  cht_ctl_t            ctl,
  output cht_sts_t            sts,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [KEY_W-1:0]    in_key,
  output logic [STATUS_W-1:0] out_status,
  output logic [POS_W-1:0]    out_position
);

  localparam int IW = $clog2(BUCKETS);
  localparam int PW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FW = $clog2(WAYS + 1);
  localparam int RW = FW + WAYS * KEY_W;
  localparam int SW = IW + 2;
  localparam logic [SW-1:0] B1 = SW'(BUCKETS);
  localparam logic [SW-1:0] B2 = SW'(2 * BUCKETS);
  localparam logic [SW-1:0] B3 = SW'(3 * BUCKETS);

  // per-byte residue tables: byte * 256^i mod BUCKETS
  logic [IW-1:0] res_tab [4][256];

  for (genvar gi = 0; gi < 4; gi++) begin : g_tab_byte
    for (genvar gj = 0; gj < 256; gj++) begin : g_tab_entry
      localparam longint unsigned Weight = (64'd1 << (8 * gi)) % BUCKETS;
      localparam longint unsigned Term   = ((gj % BUCKETS) * Weight) % BUCKETS;
      assign res_tab[gi][gj] = IW'(Term);
    end
  end

  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [IW-1:0]    part_q [4];
  logic [IW-1:0]    row_idx;
  logic [IW-1:0]    clr_idx;
  logic [RW-1:0]    rd_data;
  logic [RW-1:0]    mem [BUCKETS];

  always_ff @(posedge clk) begin
    if (ctl.ld_in) begin
      cmd_q <= in_cmd;
      key_q <= in_key;
      for (int i = 0; i < 4; i++) part_q[i] <= res_tab[i][in_key[8*i +: 8]];
    end
  end

  // sum of four residues is below 4*BUCKETS
  logic [SW-1:0] res_sum, res_red;
  logic [IW-1:0] idx;

  always_comb begin
    res_sum = SW'(part_q[0]) + SW'(part_q[1]) + SW'(part_q[2]) + SW'(part_q[3]);
    if (res_sum >= B3)      res_red = res_sum - B3;
    else if (res_sum >= B2) res_red = res_sum - B2;
    else if (res_sum >= B1) res_red = res_sum - B1;
    else                    res_red = res_sum;
    idx = res_red[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_idx <= '0;
    else if (ctl.clr_en) clr_idx <= clr_idx + 1'b1;
  end

  assign sts.clr_last = (clr_idx == IW'(BUCKETS - 1));

  // row: fill count on top, way 0 in the lowest bits
  logic [FW-1:0]    fill;
  logic [KEY_W-1:0] row_keys [WAYS];
  logic [KEY_W-1:0] shifted  [WAYS];
  logic [WAYS-1:0]  match, first, ge_mask;

  assign fill = rd_data[RW-1 -: FW];

  for (genvar gw = 0; gw < WAYS; gw++) begin : g_way
    assign row_keys[gw] = rd_data[gw*KEY_W +: KEY_W];
    assign match[gw]    = (FW'(gw) < fill) && (row_keys[gw] == key_q);
    if (gw < WAYS - 1) begin : g_shift
      assign shifted[gw] = row_keys[gw + 1];
    end else begin : g_keep
      assign shifted[gw] = row_keys[gw];
    end
  end

  assign first   = match & (~match + 1'b1);
  assign ge_mask = ~(first - 1'b1);

  logic [PW-1:0]       hit_pos;
  logic                hit, full, do_write;
  logic [FW-1:0]       fill_new;
  logic [RW-1:0]       row_new;
  logic [STATUS_W-1:0] st;
  logic [FW+2:0]       pos_fill_ext;
  logic [PW+2:0]       pos_hit_ext;
  logic [POS_W-1:0]    pos;

  always_comb begin
    hit_pos = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (first[w]) hit_pos = hit_pos | PW'(w);
    end
    hit          = |match;
    full         = (fill >= FW'(WAYS));
    pos_fill_ext = (FW+3)'(fill);
    pos_hit_ext  = (PW+3)'(hit_pos);
    do_write     = 1'b0;
    fill_new     = fill;
    st           = ST_MISS;
    pos          = '0;
    row_new      = rd_data;
    case (cmd_q)
      CMD_INSERT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          st       = ST_OK;
          pos      = pos_fill_ext[POS_W-1:0];
          do_write = 1'b1;
          fill_new = fill + 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (FW'(w) == fill) row_new[w*KEY_W +: KEY_W] = key_q;
          end
        end
      end
      CMD_SEARCH: begin
        if (hit) begin
          st  = ST_OK;
          pos = pos_hit_ext[POS_W-1:0];
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          st       = ST_OK;
          pos      = pos_hit_ext[POS_W-1:0];
          do_write = 1'b1;
          fill_new = fill - 1'b1;
          // close the gap, later keys move down one way
          for (int w = 0; w < WAYS; w++) begin
            if (ge_mask[w]) row_new[w*KEY_W +: KEY_W] = shifted[w];
          end
        end
      end
      default: st = ST_MISS;
    endcase
    row_new[RW-1 -: FW] = fill_new;
  end

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [RW-1:0] wr_data;

  assign wr_en   = ctl.clr_en | (ctl.exec & do_write);
  assign wr_idx  = ctl.clr_en ? clr_idx : row_idx;
  assign wr_data = ctl.clr_en ? '0 : row_new;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (ctl.rd_en) begin
      rd_data <= mem[idx];
      row_idx <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      out_status   <= st;
      out_position <= pos;
    end
  end

endmodule

### sv/cht_checker.sv
`timescale 1ns / 1ps

module cht_checker import cht_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [STATUS_W-1:0]  m_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // position only carries meaning on success
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
    else $error("nonzero position with failing status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_MISS || m_tuser == ST_FULL)
    else $error("undefined status code");

  // one item in flight: no new word right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in flight");

endmodule

bind chained_hash_table_engine cht_checker u_chk (.*);
